// ===== rtl/trcp_pkg.sv =====
package trcp_pkg;

  // Coordinate width of the ray fields and of the output point.
  localparam int COORD_BITS = 32;
  // Working word: covers the widest intermediate (numerator of the midpoint).
  localparam int WORD_BITS  = 5 * COORD_BITS + 8;
  localparam int RAM_DEPTH  = 32;
  localparam int RA_BITS    = $clog2(RAM_DEPTH);
  localparam int PC_BITS    = 7;

  typedef enum logic [1:0] {
    OPC_PRESS   = 2'd0,
    OPC_RELEASE = 2'd1,
    OPC_FRAME   = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    OP_END,
    OP_LD,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_TSTZ,
    OP_DIVP
  } op_t;

  typedef enum logic [1:0] {
    WS_ADD,
    WS_SUB,
    WS_UNIT,
    WS_FIELD
  } wsel_t;

  typedef enum logic {
    UOP_MUL,
    UOP_DIV
  } unit_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [RA_BITS-1:0] ra;
    logic [RA_BITS-1:0] rb;
    logic [RA_BITS-1:0] rd;
  } uop_t;

  typedef struct packed {
    logic [RA_BITS-1:0] ra;
    logic [RA_BITS-1:0] rb;
    logic [RA_BITS-1:0] rd;
    wsel_t              wsel;
    logic               ram_we;
    logic               held_we;
    logic               unit_start;
    unit_op_t           unit_op;
  } cmd_t;

  typedef struct packed {
    logic a_zero;
    logic unit_done;
  } stat_t;

  typedef struct packed {
    logic pose_valid;
    logic grab_button;
    logic parallel_rays;
  } res_t;

  // Scratch register file map.
  localparam logic [RA_BITS-1:0] R_O0X  = RA_BITS'(0);
  localparam logic [RA_BITS-1:0] R_O0Y  = RA_BITS'(1);
  localparam logic [RA_BITS-1:0] R_O0Z  = RA_BITS'(2);
  localparam logic [RA_BITS-1:0] R_D0X  = RA_BITS'(3);
  localparam logic [RA_BITS-1:0] R_D0Y  = RA_BITS'(4);
  localparam logic [RA_BITS-1:0] R_D0Z  = RA_BITS'(5);
  localparam logic [RA_BITS-1:0] R_O1X  = RA_BITS'(6);
  localparam logic [RA_BITS-1:0] R_O1Y  = RA_BITS'(7);
  localparam logic [RA_BITS-1:0] R_O1Z  = RA_BITS'(8);
  localparam logic [RA_BITS-1:0] R_D1X  = RA_BITS'(9);
  localparam logic [RA_BITS-1:0] R_D1Y  = RA_BITS'(10);
  localparam logic [RA_BITS-1:0] R_D1Z  = RA_BITS'(11);
  localparam logic [RA_BITS-1:0] R_BX   = RA_BITS'(12);
  localparam logic [RA_BITS-1:0] R_BY   = RA_BITS'(13);
  localparam logic [RA_BITS-1:0] R_BZ   = RA_BITS'(14);
  localparam logic [RA_BITS-1:0] R_NX   = RA_BITS'(15);
  localparam logic [RA_BITS-1:0] R_NY   = RA_BITS'(16);
  localparam logic [RA_BITS-1:0] R_NZ   = RA_BITS'(17);
  localparam logic [RA_BITS-1:0] R_DEN  = RA_BITS'(18);
  localparam logic [RA_BITS-1:0] R_E1   = RA_BITS'(19);
  localparam logic [RA_BITS-1:0] R_E2   = RA_BITS'(20);
  localparam logic [RA_BITS-1:0] R_C1X  = RA_BITS'(21);
  localparam logic [RA_BITS-1:0] R_C1Y  = RA_BITS'(22);
  localparam logic [RA_BITS-1:0] R_C1Z  = RA_BITS'(23);
  localparam logic [RA_BITS-1:0] R_C0X  = RA_BITS'(24);
  localparam logic [RA_BITS-1:0] R_C0Y  = RA_BITS'(25);
  localparam logic [RA_BITS-1:0] R_C0Z  = RA_BITS'(26);
  localparam logic [RA_BITS-1:0] R_S    = RA_BITS'(27);
  localparam logic [RA_BITS-1:0] R_T    = RA_BITS'(28);
  localparam logic [RA_BITS-1:0] R_DEN2 = RA_BITS'(29);
  localparam logic [RA_BITS-1:0] R_SUM  = RA_BITS'(30);

  // Input field selects for OP_LD (in ra).
  localparam logic [RA_BITS-1:0] F_OX = RA_BITS'(0);
  localparam logic [RA_BITS-1:0] F_OY = RA_BITS'(1);
  localparam logic [RA_BITS-1:0] F_OZ = RA_BITS'(2);
  localparam logic [RA_BITS-1:0] F_DX = RA_BITS'(3);
  localparam logic [RA_BITS-1:0] F_DY = RA_BITS'(4);
  localparam logic [RA_BITS-1:0] F_DZ = RA_BITS'(5);

  // Point axis for OP_DIVP (in rd).
  localparam logic [RA_BITS-1:0] AX_X = RA_BITS'(0);
  localparam logic [RA_BITS-1:0] AX_Y = RA_BITS'(1);
  localparam logic [RA_BITS-1:0] AX_Z = RA_BITS'(2);
  localparam logic [RA_BITS-1:0] R_NONE = RA_BITS'(0);

  localparam logic [PC_BITS-1:0] PC_STORE = PC_BITS'(0);
  localparam logic [PC_BITS-1:0] PC_SOLVE = PC_BITS'(7);

  function automatic uop_t mk(input op_t o, input logic [RA_BITS-1:0] a,
                              input logic [RA_BITS-1:0] b,
                              input logic [RA_BITS-1:0] d);
    uop_t u;
    u.op = o;
    u.ra = a;
    u.rb = b;
    u.rd = d;
    return u;
  endfunction

  // Microprogram. Multiplies put the short operand in rb (serial side).
  function automatic uop_t prog(input logic [PC_BITS-1:0] pc);
    uop_t u;
    case (int'(pc))
      // store first ray
      0:  u = mk(OP_LD,  F_OX,  R_NONE, R_O0X);
      1:  u = mk(OP_LD,  F_OY,  R_NONE, R_O0Y);
      2:  u = mk(OP_LD,  F_OZ,  R_NONE, R_O0Z);
      3:  u = mk(OP_LD,  F_DX,  R_NONE, R_D0X);
      4:  u = mk(OP_LD,  F_DY,  R_NONE, R_D0Y);
      5:  u = mk(OP_LD,  F_DZ,  R_NONE, R_D0Z);
      6:  u = mk(OP_END, R_NONE, R_NONE, R_NONE);
      // solve
      7:  u = mk(OP_LD,  F_OX,  R_NONE, R_O1X);
      8:  u = mk(OP_LD,  F_OY,  R_NONE, R_O1Y);
      9:  u = mk(OP_LD,  F_OZ,  R_NONE, R_O1Z);
      10: u = mk(OP_LD,  F_DX,  R_NONE, R_D1X);
      11: u = mk(OP_LD,  F_DY,  R_NONE, R_D1Y);
      12: u = mk(OP_LD,  F_DZ,  R_NONE, R_D1Z);
      13: u = mk(OP_SUB, R_O1X, R_O0X, R_BX);
      14: u = mk(OP_SUB, R_O1Y, R_O0Y, R_BY);
      15: u = mk(OP_SUB, R_O1Z, R_O0Z, R_BZ);
      // N = d0 x d1
      16: u = mk(OP_MUL, R_D0Y, R_D1Z, R_E1);
      17: u = mk(OP_MUL, R_D0Z, R_D1Y, R_E2);
      18: u = mk(OP_SUB, R_E1,  R_E2,  R_NX);
      19: u = mk(OP_MUL, R_D0Z, R_D1X, R_E1);
      20: u = mk(OP_MUL, R_D0X, R_D1Z, R_E2);
      21: u = mk(OP_SUB, R_E1,  R_E2,  R_NY);
      22: u = mk(OP_MUL, R_D0X, R_D1Y, R_E1);
      23: u = mk(OP_MUL, R_D0Y, R_D1X, R_E2);
      24: u = mk(OP_SUB, R_E1,  R_E2,  R_NZ);
      // D = N.N
      25: u = mk(OP_MUL, R_NX,  R_NX,  R_E1);
      26: u = mk(OP_MUL, R_NY,  R_NY,  R_E2);
      27: u = mk(OP_ADD, R_E1,  R_E2,  R_E1);
      28: u = mk(OP_MUL, R_NZ,  R_NZ,  R_E2);
      29: u = mk(OP_ADD, R_E1,  R_E2,  R_DEN);
      30: u = mk(OP_TSTZ, R_DEN, R_NONE, R_NONE);
      // C1 = B x d1
      31: u = mk(OP_MUL, R_BY,  R_D1Z, R_E1);
      32: u = mk(OP_MUL, R_BZ,  R_D1Y, R_E2);
      33: u = mk(OP_SUB, R_E1,  R_E2,  R_C1X);
      34: u = mk(OP_MUL, R_BZ,  R_D1X, R_E1);
      35: u = mk(OP_MUL, R_BX,  R_D1Z, R_E2);
      36: u = mk(OP_SUB, R_E1,  R_E2,  R_C1Y);
      37: u = mk(OP_MUL, R_BX,  R_D1Y, R_E1);
      38: u = mk(OP_MUL, R_BY,  R_D1X, R_E2);
      39: u = mk(OP_SUB, R_E1,  R_E2,  R_C1Z);
      // C0 = B x d0
      40: u = mk(OP_MUL, R_BY,  R_D0Z, R_E1);
      41: u = mk(OP_MUL, R_BZ,  R_D0Y, R_E2);
      42: u = mk(OP_SUB, R_E1,  R_E2,  R_C0X);
      43: u = mk(OP_MUL, R_BZ,  R_D0X, R_E1);
      44: u = mk(OP_MUL, R_BX,  R_D0Z, R_E2);
      45: u = mk(OP_SUB, R_E1,  R_E2,  R_C0Y);
      46: u = mk(OP_MUL, R_BX,  R_D0Y, R_E1);
      47: u = mk(OP_MUL, R_BY,  R_D0X, R_E2);
      48: u = mk(OP_SUB, R_E1,  R_E2,  R_C0Z);
      // s = C1.N
      49: u = mk(OP_MUL, R_C1X, R_NX,  R_E1);
      50: u = mk(OP_MUL, R_C1Y, R_NY,  R_E2);
      51: u = mk(OP_ADD, R_E1,  R_E2,  R_E1);
      52: u = mk(OP_MUL, R_C1Z, R_NZ,  R_E2);
      53: u = mk(OP_ADD, R_E1,  R_E2,  R_S);
      // t = C0.N
      54: u = mk(OP_MUL, R_C0X, R_NX,  R_E1);
      55: u = mk(OP_MUL, R_C0Y, R_NY,  R_E2);
      56: u = mk(OP_ADD, R_E1,  R_E2,  R_E1);
      57: u = mk(OP_MUL, R_C0Z, R_NZ,  R_E2);
      58: u = mk(OP_ADD, R_E1,  R_E2,  R_T);
      59: u = mk(OP_ADD, R_DEN, R_DEN, R_DEN2);
      // x
      60: u = mk(OP_ADD, R_O0X, R_O1X, R_SUM);
      61: u = mk(OP_MUL, R_DEN, R_SUM, R_E1);
      62: u = mk(OP_MUL, R_S,   R_D0X, R_E2);
      63: u = mk(OP_ADD, R_E1,  R_E2,  R_E1);
      64: u = mk(OP_MUL, R_T,   R_D1X, R_E2);
      65: u = mk(OP_ADD, R_E1,  R_E2,  R_E1);
      66: u = mk(OP_ADD, R_E1,  R_DEN, R_E1);
      67: u = mk(OP_DIVP, R_E1, R_DEN2, AX_X);
      // y
      68: u = mk(OP_ADD, R_O0Y, R_O1Y, R_SUM);
      69: u = mk(OP_MUL, R_DEN, R_SUM, R_E1);
      70: u = mk(OP_MUL, R_S,   R_D0Y, R_E2);
      71: u = mk(OP_ADD, R_E1,  R_E2,  R_E1);
      72: u = mk(OP_MUL, R_T,   R_D1Y, R_E2);
      73: u = mk(OP_ADD, R_E1,  R_E2,  R_E1);
      74: u = mk(OP_ADD, R_E1,  R_DEN, R_E1);
      75: u = mk(OP_DIVP, R_E1, R_DEN2, AX_Y);
      // z
      76: u = mk(OP_ADD, R_O0Z, R_O1Z, R_SUM);
      77: u = mk(OP_MUL, R_DEN, R_SUM, R_E1);
      78: u = mk(OP_MUL, R_S,   R_D0Z, R_E2);
      79: u = mk(OP_ADD, R_E1,  R_E2,  R_E1);
      80: u = mk(OP_MUL, R_T,   R_D1Z, R_E2);
      81: u = mk(OP_ADD, R_E1,  R_E2,  R_E1);
      82: u = mk(OP_ADD, R_E1,  R_DEN, R_E1);
      83: u = mk(OP_DIVP, R_E1, R_DEN2, AX_Z);
      default: u = mk(OP_END, R_NONE, R_NONE, R_NONE);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/trcp_ram.sv =====
module trcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/trcp_dp.sv =====
module trcp_dp import trcp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic signed [COORD_BITS-1:0] origin_z,
  input  logic signed [COORD_BITS-1:0] dir_x,
  input  logic signed [COORD_BITS-1:0] dir_y,
  input  logic signed [COORD_BITS-1:0] dir_z,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z
);

  localparam int W        = WORD_BITS;
  localparam int CNT_BITS = $clog2(W + 1);

  logic [W-1:0] rdata_a, rdata_b, wdata;
  logic signed [COORD_BITS-1:0] field;

  // two copies of the scratch file give two read ports
  trcp_ram #(.WIDTH(W), .DEPTH(RAM_DEPTH)) u_ram_a (
    .clk(clk), .we(cmd.ram_we), .waddr(cmd.rd), .wdata(wdata),
    .raddr(cmd.ra), .rdata(rdata_a)
  );

  trcp_ram #(.WIDTH(W), .DEPTH(RAM_DEPTH)) u_ram_b (
    .clk(clk), .we(cmd.ram_we), .waddr(cmd.rd), .wdata(wdata),
    .raddr(cmd.rb), .rdata(rdata_b)
  );

  always_comb begin
    case (cmd.ra)
      F_OX:    field = origin_x;
      F_OY:    field = origin_y;
      F_OZ:    field = origin_z;
      F_DX:    field = dir_x;
      F_DY:    field = dir_y;
      F_DZ:    field = dir_z;
      default: field = origin_x;
    endcase
  end

  // shared multiply / divide unit
  logic               busy, done, neg;
  unit_op_t           mode;
  logic [W-1:0]       ua, ub, res;
  logic [W:0]         acc, rem2;
  logic [CNT_BITS-1:0] cnt;
  logic [W-1:0]       abs_a, abs_b;
  logic               ge;

  assign abs_a = rdata_a[W-1] ? (~rdata_a + W'(1)) : rdata_a;
  assign abs_b = rdata_b[W-1] ? (~rdata_b + W'(1)) : rdata_b;
  assign rem2  = {acc[W-1:0], ua[W-1]};
  assign ge    = (rem2 >= {1'b0, ub});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.unit_start) begin
        busy <= 1'b1;
        mode <= cmd.unit_op;
        ua   <= abs_a;
        ub   <= (cmd.unit_op == UOP_MUL) ? abs_b : rdata_b;
        acc  <= '0;
        neg  <= (cmd.unit_op == UOP_MUL) ? (rdata_a[W-1] ^ rdata_b[W-1]) : rdata_a[W-1];
        cnt  <= CNT_BITS'(W);
      end else if (busy) begin
        if (mode == UOP_MUL) begin
          // shift-add, one multiplier bit a cycle, stops when bits run out
          if (ub == '0) begin
            res  <= neg ? (~acc[W-1:0] + W'(1)) : acc[W-1:0];
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            if (ub[0]) begin
              acc <= acc + {1'b0, ua};
            end
            ua <= ua << 1;
            ub <= ub >> 1;
          end
        end else begin
          // restoring divide; ua shifts the dividend out and the quotient in
          if (cnt == '0) begin
            // floor for a negative dividend: -(q + (rem != 0))
            res  <= neg ? (~ua + W'(acc == '0)) : ua;
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            acc <= ge ? (rem2 - {1'b0, ub}) : rem2;
            ua  <= {ua[W-2:0], ge};
            cnt <= cnt - CNT_BITS'(1);
          end
        end
      end
    end
  end

  always_comb begin
    case (cmd.wsel)
      WS_ADD:   wdata = rdata_a + rdata_b;
      WS_SUB:   wdata = rdata_a - rdata_b;
      WS_UNIT:  wdata = res;
      WS_FIELD: wdata = W'(field);
      default:  wdata = res;
    endcase
  end

  // saturate quotient to a coordinate
  logic                         ovf;
  logic signed [COORD_BITS-1:0] sat;

  assign ovf = (res[W-1:COORD_BITS-1] != {(W-COORD_BITS+1){res[W-1]}});
  always_comb begin
    if (!ovf) begin
      sat = res[COORD_BITS-1:0];
    end else if (res[W-1]) begin
      sat = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_x <= '0;
      point_y <= '0;
      point_z <= '0;
    end else if (cmd.held_we) begin
      case (cmd.rd)
        AX_X:    point_x <= sat;
        AX_Y:    point_y <= sat;
        AX_Z:    point_z <= sat;
        default: point_x <= point_x;
      endcase
    end
  end

  assign stat.a_zero    = (rdata_a == '0);
  assign stat.unit_done = done;

endmodule

// ===== rtl/trcp_ctrl.sv =====
module trcp_ctrl import trcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic       out_free,
  output logic       fin,
  output res_t       res,
  output cmd_t       cmd,
  input  stat_t      stat
);

  state_t             state, state_next;
  logic [PC_BITS-1:0] pc, pc_next;
  logic [1:0]         rc, rc_next;
  logic               drag, drag_next;
  logic               btn, btn_next;
  logic               par, par_next;
  uop_t               u;

  assign u = prog(pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      rc    <= '0;
      drag  <= 1'b0;
      btn   <= 1'b0;
      par   <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      rc    <= rc_next;
      drag  <= drag_next;
      btn   <= btn_next;
      par   <= par_next;
    end
  end

  always_comb begin
    state_next     = state;
    pc_next        = pc;
    rc_next        = rc;
    drag_next      = drag;
    btn_next       = btn;
    par_next       = par;
    in_ready       = 1'b0;
    fin            = 1'b0;
    cmd.ra         = u.ra;
    cmd.rb         = u.rb;
    cmd.rd         = u.rd;
    cmd.wsel       = WS_ADD;
    cmd.ram_we     = 1'b0;
    cmd.held_we    = 1'b0;
    cmd.unit_start = 1'b0;
    cmd.unit_op    = UOP_MUL;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          par_next   = 1'b0;
          state_next = S_FINISH;
          case (opcode_t'(opcode))
            OPC_PRESS: begin
              if (rc == 2'd2) begin
                rc_next = 2'd0;
              end else if (rc == 2'd1) begin
                btn_next = 1'b1;
              end
              drag_next = 1'b1;
            end
            OPC_RELEASE: begin
              if (rc != 2'd3) begin
                rc_next = rc + 2'd1;
              end
              if (rc == 2'd1) begin
                btn_next = 1'b0;
              end
              drag_next = 1'b0;
            end
            OPC_FRAME: begin
              if (drag && rc == 2'd0) begin
                pc_next    = PC_STORE;
                state_next = S_FETCH;
              end else if (drag && rc == 2'd1) begin
                pc_next    = PC_SOLVE;
                state_next = S_FETCH;
              end
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_FETCH: begin
        case (u.op)
          OP_END: state_next = S_FINISH;
          OP_LD: begin
            cmd.ram_we = 1'b1;
            cmd.wsel   = WS_FIELD;
            pc_next    = pc + PC_BITS'(1);
          end
          default: state_next = S_EXEC;
        endcase
      end
      S_EXEC: begin
        case (u.op)
          OP_ADD: begin
            cmd.ram_we = 1'b1;
            cmd.wsel   = WS_ADD;
            pc_next    = pc + PC_BITS'(1);
            state_next = S_FETCH;
          end
          OP_SUB: begin
            cmd.ram_we = 1'b1;
            cmd.wsel   = WS_SUB;
            pc_next    = pc + PC_BITS'(1);
            state_next = S_FETCH;
          end
          OP_TSTZ: begin
            if (stat.a_zero) begin
              par_next   = 1'b1;
              state_next = S_FINISH;
            end else begin
              pc_next    = pc + PC_BITS'(1);
              state_next = S_FETCH;
            end
          end
          OP_MUL: begin
            cmd.unit_start = 1'b1;
            cmd.unit_op    = UOP_MUL;
            state_next     = S_WAIT;
          end
          OP_DIVP: begin
            cmd.unit_start = 1'b1;
            cmd.unit_op    = UOP_DIV;
            state_next     = S_WAIT;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_WAIT: begin
        if (stat.unit_done) begin
          if (u.op == OP_MUL) begin
            cmd.ram_we = 1'b1;
            cmd.wsel   = WS_UNIT;
          end else begin
            cmd.held_we = 1'b1;
          end
          pc_next    = pc + PC_BITS'(1);
          state_next = S_FETCH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign res.pose_valid    = drag ? (rc != 2'd0) : rc[1];
  assign res.grab_button   = btn;
  assign res.parallel_rays = par;

  a_count_sticks: assert property (@(posedge clk) disable iff (rst)
    (rc == 2'd3) |=> (rc == 2'd3))
    else $error("ray count left saturation");

  a_fin_room: assert property (@(posedge clk) disable iff (rst)
    fin |-> out_free)
    else $error("result issued with output register full");

  a_par_in_solve: assert property (@(posedge clk) disable iff (rst)
    par |-> (drag && rc == 2'd1))
    else $error("parallel flag outside a solve");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.unit_start |=> !stat.unit_done)
    else $error("unit done right after start");

endmodule

// ===== rtl/two_ray_closest_point_top.sv =====
// Two-ray point picker. Items are button presses, releases and frames that
// carry a ray (origin and direction, signed Q16.16). While the button is held
// with no finished ray, each frame stores its ray; with one finished ray, each
// frame solves for the midpoint of closest approach between the stored ray and
// the new one and holds it (rays that are parallel or zero keep the old point
// and raise parallel_rays). Every item gives exactly one result item with the
// pose flag, the held point, the grab button and the parallel flag. Items are
// taken one at a time, a new one only once the last has finished. Press,
// release, unused opcodes and frames that do no work go straight to the
// finish; storing a ray loads its six fields. A solve runs a microprogram on
// one shared unit: 36 products on a shift-add multiplier that retires one
// multiplier bit a cycle and stops when the bits of the short operand run
// out, and three 168-step restoring divides. Rays found parallel stop right
// after the determinant test. The scratch file is a 32-entry RAM needing no
// clearing. The next item is accepted while a finished result still waits in
// the output register; the finish of that next item waits until the register
// is free.
module two_ray_closest_point_top import trcp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic signed [COORD_BITS-1:0] origin_z,
  input  logic signed [COORD_BITS-1:0] dir_x,
  input  logic signed [COORD_BITS-1:0] dir_y,
  input  logic signed [COORD_BITS-1:0] dir_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pose_valid,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic                         grab_button,
  output logic                         parallel_rays
);

  // captured ray of the item in work
  logic signed [COORD_BITS-1:0] ox, oy, oz, dx, dy, dz;
  logic signed [COORD_BITS-1:0] hx, hy, hz;
  logic  accept, fin, out_free;
  res_t  res;
  cmd_t  cmd;
  stat_t stat;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      ox <= origin_x;
      oy <= origin_y;
      oz <= origin_z;
      dx <= dir_x;
      dy <= dir_y;
      dz <= dir_z;
    end
  end

  trcp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .out_free(out_free), .fin(fin), .res(res),
    .cmd(cmd), .stat(stat)
  );

  trcp_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .origin_x(ox), .origin_y(oy), .origin_z(oz),
    .dir_x(dx), .dir_y(dy), .dir_z(dz),
    .point_x(hx), .point_y(hy), .point_z(hz)
  );

  // output register: holds a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      pose_valid    <= res.pose_valid;
      grab_button   <= res.grab_button;
      parallel_rays <= res.parallel_rays;
      point_x       <= hx;
      point_y       <= hy;
      point_z       <= hz;
    end
  end

endmodule

// ===== sim/two_ray_closest_point_top_test.sv =====
module two_ray_closest_point_top_test;
  import trcp_pkg::*;

  // Wide enough for every intermediate of the solve (products reach ~2^162).
  typedef logic signed [255:0] wide_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic [1:0] op;
    coord_t     org[3];
    coord_t     dir[3];
  } ray_item_t;

  typedef struct {
    logic   pose;
    coord_t pt[3];
    logic   grab;
    logic   par;
  } pose_res_t;

  // Scoreboard: tracks the picker's state, predicts one result per item
  // and compares results against the oldest prediction.
  class pick_scoreboard;
    logic [1:0] rays;
    logic       drag;
    logic       btn;
    logic       first_seen;
    coord_t     o0[3], d0[3], held[3];
    pose_res_t  pending[$];
    int         errors, n_results, n_solves, n_parallel;

    function new();
      rays = 0; drag = 0; btn = 0; first_seen = 0;
      errors = 0; n_results = 0; n_solves = 0; n_parallel = 0;
      for (int i = 0; i < 3; i++) begin
        o0[i] = '0; d0[i] = '0; held[i] = '0;
      end
    endfunction

    // A solve before any first ray was stored reads an undefined store.
    function bit reads_unset(logic [1:0] op);
      return op == OPC_FRAME && drag && rays == 2'd1 && !first_seen;
    endfunction

    function void cross3(input wide_t a[3], input wide_t b[3], output wide_t c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function wide_t dot3(input wide_t a[3], input wide_t b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Floor divide by a positive divisor, then clamp to the coordinate range.
    function coord_t floor_sat(wide_t n, wide_t d);
      wide_t q;
      wide_t pmax, pmin;
      pmax = wide_t'(coord_t'({1'b0, {(COORD_BITS-1){1'b1}}}));
      pmin = wide_t'(coord_t'({1'b1, {(COORD_BITS-1){1'b0}}}));
      q = n / d;
      if (n < 0 && (n % d) != 0) q = q - 1;
      if (q > pmax) return coord_t'(pmax);
      if (q < pmin) return coord_t'(pmin);
      return coord_t'(q);
    endfunction

    // Midpoint of closest approach; returns 1 when the rays are parallel.
    function bit midpoint(ray_item_t it);
      wide_t a0[3], a1[3], e0[3], e1[3], bv[3], nv[3], c1[3], c0[3];
      wide_t den, s, t, num;
      for (int i = 0; i < 3; i++) begin
        a0[i] = o0[i]; e0[i] = d0[i];
        a1[i] = it.org[i]; e1[i] = it.dir[i];
        bv[i] = a1[i] - a0[i];
      end
      cross3(e0, e1, nv);
      den = dot3(nv, nv);
      if (den == 0) return 1;
      cross3(bv, e1, c1);
      cross3(bv, e0, c0);
      s = dot3(c1, nv);
      t = dot3(c0, nv);
      for (int i = 0; i < 3; i++) begin
        num = (a0[i] + a1[i]) * den + s * e0[i] + t * e1[i];
        held[i] = floor_sat(num + den, den + den);
      end
      return 0;
    endfunction

    function void note_item(ray_item_t it);
      pose_res_t r;
      r.par = 0;
      case (it.op)
        OPC_PRESS: begin
          if (rays == 2'd2) rays = 0;
          else if (rays == 2'd1) btn = 1;
          drag = 1;
        end
        OPC_RELEASE: begin
          if (rays != 2'd3) rays = rays + 1;
          if (rays == 2'd2) btn = 0;
          drag = 0;
        end
        OPC_FRAME: begin
          if (drag && rays == 2'd0) begin
            o0 = it.org; d0 = it.dir; first_seen = 1;
          end else if (drag && rays == 2'd1) begin
            r.par = midpoint(it);
            n_solves++;
            if (r.par) n_parallel++;
          end
        end
        default: ;
      endcase
      r.pose = rays >= (drag ? 2'd1 : 2'd2);
      r.pt = held;
      r.grab = btn;
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH result %0d %s: got %h want %h", n_results, what, got, want);
      errors++;
    endtask

    task check_result(pose_res_t got);
      pose_res_t want;
      n_results++;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", 64'd1, 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.pose !== want.pose) report_mismatch("pose_valid", got.pose, want.pose);
      if (got.pt[0] !== want.pt[0]) report_mismatch("point_x", got.pt[0], want.pt[0]);
      if (got.pt[1] !== want.pt[1]) report_mismatch("point_y", got.pt[1], want.pt[1]);
      if (got.pt[2] !== want.pt[2]) report_mismatch("point_z", got.pt[2], want.pt[2]);
      if (got.grab !== want.grab) report_mismatch("grab_button", got.grab, want.grab);
      if (got.par !== want.par) report_mismatch("parallel_rays", got.par, want.par);
    endtask
  endclass

  localparam int IDLE_LIMIT = 20000;  // cycles with no item moving on either side

  logic   clk, rst;
  logic   in_valid, in_ready, out_valid, out_ready;
  logic [1:0] opcode;
  coord_t origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
  logic   pose_valid, grab_button, parallel_rays;
  coord_t point_x, point_y, point_z;

  two_ray_closest_point_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .pose_valid(pose_valid),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .grab_button(grab_button), .parallel_rays(parallel_rays)
  );

  pick_scoreboard sb = new();
  int items_sent;
  int burst_left;
  int hold_off;     // receiver back-pressure request, in cycles
  int idle_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Receiver: its own stall pattern, plus a long hold-off on request.
  initial begin
    int mode;
    out_ready = 0;
    hold_off = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 0;
      end else begin
        case (mode)
          0: out_ready <= 1;                            // no stalls
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 1) != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Result monitor and idle watchdog.
  always @(posedge clk) begin
    pose_res_t r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        r.pose = pose_valid;
        r.pt[0] = point_x; r.pt[1] = point_y; r.pt[2] = point_z;
        r.grab = grab_button;
        r.par = parallel_rays;
        sb.check_result(r);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("two_ray_closest_point_top_test: done, errors");
        $finish;
      end
    end
  end

  // Offer one item and hold it until taken. Entered and left at a rising edge,
  // so a following item in the same burst keeps in_valid high without a drop.
  task automatic send(ray_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 6);
    end
    burst_left--;
    if (sb.reads_unset(it.op)) it.op = 2'd3;  // never solve against an empty store
    in_valid <= 1;
    opcode   <= it.op;
    origin_x <= it.org[0]; origin_y <= it.org[1]; origin_z <= it.org[2];
    dir_x    <= it.dir[0]; dir_y    <= it.dir[1]; dir_z    <= it.dir[2];
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    items_sent++;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return coord_t'($urandom);
      2:    return coord_t'($urandom_range(0, 32'h3_ffff)) - coord_t'(32'h2_0000);
      3:    return coord_t'($urandom_range(0, 255)) - coord_t'(128);
      4:    return ($urandom_range(0, 1) != 0) ? coord_t'(32'h7fff_ffff)
                                               : coord_t'(32'h8000_0000);
      default: return coord_t'($urandom_range(0, 32'h00ff_ffff)) - coord_t'(32'h0080_0000);
    endcase
  endfunction

  function automatic ray_item_t mk_item(logic [1:0] op, coord_t ox, coord_t oy, coord_t oz,
                                        coord_t dx, coord_t dy, coord_t dz);
    ray_item_t it;
    it.op = op;
    it.org[0] = ox; it.org[1] = oy; it.org[2] = oz;
    it.dir[0] = dx; it.dir[1] = dy; it.dir[2] = dz;
    return it;
  endfunction

  // Frame with random ray; now and then a direction parallel to the stored
  // one, its negation, or zero.
  function automatic ray_item_t rand_frame();
    ray_item_t it;
    int k;
    it = mk_item(OPC_FRAME, rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (k == 0) it.dir[i] = sb.d0[i];
      else if (k == 1) it.dir[i] = -sb.d0[i];
      else if (k == 2) it.dir[i] = '0;
    end
    return it;
  endfunction

  function automatic ray_item_t bare(logic [1:0] op);
    ray_item_t it;
    it = rand_frame();
    it.op = op;
    return it;
  endfunction

  // One well-formed two-ray gesture: store a ray, then solve against it.
  task automatic gesture();
    send(bare(OPC_PRESS));
    repeat ($urandom_range(1, 2)) send(rand_frame());
    send(bare(OPC_RELEASE));
    send(bare(OPC_PRESS));
    repeat ($urandom_range(1, 3)) send(rand_frame());
    send(bare(OPC_RELEASE));
  endtask

  localparam coord_t CMAX = coord_t'(32'h7fff_ffff);
  localparam coord_t CMIN = coord_t'(32'h8000_0000);
  localparam coord_t ONE  = coord_t'(32'h0001_0000);

  initial begin
    rst = 1;
    in_valid = 0;
    opcode = OPC_PRESS;
    origin_x = '0; origin_y = '0; origin_z = '0;
    dir_x = '0; dir_y = '0; dir_z = '0;
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: store at the extremes, solve at the extremes, parallel and
    // zero directions, frames with nothing to do.
    send(mk_item(OPC_FRAME, ONE, ONE, ONE, ONE, 0, 0));       // not dragging: ignored
    send(mk_item(OPC_PRESS, 0, 0, 0, 0, 0, 0));
    send(mk_item(OPC_FRAME, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send(mk_item(OPC_FRAME, 0, 0, 0, ONE, 0, 0));
    send(mk_item(OPC_RELEASE, 0, 0, 0, 0, 0, 0));
    send(mk_item(OPC_PRESS, 0, 0, 0, 0, 0, 0));               // grab goes high
    send(mk_item(OPC_FRAME, 0, ONE, 0, 0, 0, ONE));           // simple skew pair
    send(mk_item(OPC_FRAME, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN));
    send(mk_item(OPC_FRAME, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
    send(mk_item(OPC_FRAME, ONE, ONE, ONE, -ONE, 0, 0));      // parallel
    send(mk_item(OPC_FRAME, ONE, ONE, ONE, 0, 0, 0));         // zero direction
    send(mk_item(2'd3, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));  // unused opcode
    send(mk_item(OPC_RELEASE, 0, 0, 0, 0, 0, 0));             // count 2, grab low
    send(mk_item(OPC_PRESS, 0, 0, 0, 0, 0, 0));               // count back to 0
    send(mk_item(OPC_RELEASE, 0, 0, 0, 0, 0, 0));
    send(mk_item(OPC_RELEASE, 0, 0, 0, 0, 0, 0));
    send(mk_item(OPC_PRESS, 0, 0, 0, 0, 0, 0));

    // Random: mostly gestures, some loose items.
    while (items_sent < 640) begin
      if (items_sent > 200 && items_sent < 215 && hold_off == 0) hold_off = 400;
      if ($urandom_range(0, 3) == 0) send(bare(2'($urandom_range(0, 3))));
      else if ($urandom_range(0, 4) == 0) send(rand_frame());
      else gesture();
    end

    // Saturated count last: once at 3 the count never leaves it.
    send(bare(OPC_RELEASE));
    send(bare(OPC_RELEASE));
    send(bare(OPC_RELEASE));
    send(bare(OPC_PRESS));
    send(rand_frame());
    send(bare(2'd3));
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d items, %0d results, %0d solves (%0d parallel or degenerate)",
             items_sent, sb.n_results, sb.n_solves, sb.n_parallel);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("two_ray_closest_point_top_test: done, clean");
    else
      $display("two_ray_closest_point_top_test: done, errors");
    $finish;
  end

endmodule
